FILE: src/sha256_pkg.sv
// Package with SHA-256 constants, types and round functions.
`default_nettype none
package sha256_pkg;

  localparam int unsigned WordBits = 32;

  typedef logic [WordBits-1:0] word_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85; 3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a; 3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordBits - n));
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_byte;   // write in_data_byte at the fill position
    logic       pad_byte;    // write 0x80 at the fill position
    logic       clear_tail;  // zero bytes after the fill position
    logic       clear_all;   // zero every byte
    logic       put_length;  // write the bit length into the last eight bytes
    logic       start_comp;  // load working variables, clear fill and round counts
    logic       round;       // run one round
    logic       finish_comp; // fold working variables into the hash
    logic       reset_msg;   // restore initial hash, counts to zero
    logic       shift_out;   // rotate the hash toward word 0 after a word is sent
  } sha_cmd_t;

  typedef struct packed {
    logic       block_full;  // 64 bytes are pending
    logic       need_extra;  // 56 or more bytes pending at the end
    logic       rounds_done; // round 63 is in progress
  } sha_sts_t;

endpackage
`default_nettype wire

FILE: src/sha256_if.sv
// Valid/ready channel interfaces for the hasher.
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       final_byte;
  modport source (output valid, data_byte, has_byte, final_byte, input ready);
  modport sink (input valid, data_byte, has_byte, final_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: src/sha256_datapath.sv
// Message block, message schedule, round logic and hash state.
`default_nettype none
module sha256_datapath
  import sha256_pkg::*;
#(
  parameter int unsigned LENGTH_COUNT_BITS = 61
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire sha_cmd_t cmd,
  input  wire logic [7:0] data_byte,
  output sha_sts_t      sts,
  output word_t         hash0
);

  // The message bytes are packed straight into the sixteen-word schedule window,
  // big-endian within each word; the rounds then turn it into the rolling schedule.
  word_t w_r [16];
  word_t w_nxt [16];
  word_t v_r [8];
  word_t h_r [8];
  logic [LENGTH_COUNT_BITS-1:0] cnt_r;
  logic [6:0] fill_r;
  logic [5:0] rnd_r;

  logic [63:0] bit_len;
  word_t w_new, t1, t2, s0, s1, w15, w2;

  assign bit_len = 64'(cnt_r) << 3;
  assign w15 = w_r[1];
  assign w2  = w_r[14];
  assign s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign w_new = w_r[0] + s0 + w_r[9] + s1;
  // w_r[0] is always the word of the current round; the window shifts each round.
  assign t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(rnd_r) + w_r[0];
  assign t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign sts.block_full  = fill_r[6];
  assign sts.need_extra  = (fill_r[5:0] >= 6'd56);
  assign sts.rounds_done = (rnd_r == 6'd63);
  assign hash0 = h_r[0];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_nxt[i] = w_r[i];
    end
    for (int i = 0; i < 64; i++) begin
      if (cmd.clear_all || (cmd.clear_tail && 6'(i) > fill_r[5:0])) begin
        w_nxt[4'(i >> 2)][8 * (3 - (i & 3)) +: 8] = 8'h00;
      end
    end
    if (cmd.load_byte) begin
      w_nxt[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] = data_byte;
    end
    if (cmd.pad_byte) begin
      w_nxt[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] = 8'h80;
    end
    if (cmd.put_length) begin
      w_nxt[14] = bit_len[63:32];
      w_nxt[15] = bit_len[31:0];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[15] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      w_r[i] <= w_nxt[i];
    end
    if (cmd.start_comp) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end
    if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_msg) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= init_hash(3'(i));
      end
      cnt_r  <= '0;
      fill_r <= '0;
      rnd_r  <= '0;
    end else begin
      if (cmd.load_byte) begin
        fill_r <= fill_r + 7'd1;
        cnt_r  <= cnt_r + {{(LENGTH_COUNT_BITS-1){1'b0}}, 1'b1};
      end
      if (cmd.start_comp) begin
        fill_r <= '0;
        rnd_r  <= '0;
      end
      if (cmd.round) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.finish_comp) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end
      if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) begin
          h_r[i] <= h_r[i+1];
        end
        h_r[7] <= h_r[0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/sha256_ctrl.sv
// Controller state machine sequencing bytes, padding, rounds and output.
`default_nettype none
module sha256_ctrl
  import sha256_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     has_byte,
  input  wire logic     final_byte,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [2:0]    word_index,
  output sha_cmd_t      cmd,
  input  wire sha_sts_t sts
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_ROUND = 8'b0000_0100,
    ST_FOLD  = 8'b0000_1000,
    ST_PAD   = 8'b0001_0000,
    ST_LEN   = 8'b0010_0000,
    ST_START = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic final_r, final_nxt;   // the message end is pending
  logic last_r, last_nxt;     // the running compression holds the length
  logic [2:0] idx_r, idx_nxt;
  // Set from the padding of a long tail until the length block is written.
  logic pend_extra_r, pend_extra_nxt;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = (state_r == ST_OUT);
  assign word_index = idx_r;

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = has_byte;
          final_nxt = final_byte;
          if (has_byte || final_byte) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts.block_full) begin
          state_nxt = ST_START;
        end else if (final_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd.pad_byte   = 1'b1;
        cmd.clear_tail = 1'b1;
        final_nxt = 1'b0;
        state_nxt = sts.need_extra ? ST_START : ST_LEN;
        last_nxt  = !sts.need_extra;
        if (!sts.need_extra) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        // After the extra block of a long tail the whole block is zeroed first.
        cmd.put_length = 1'b1;
        cmd.clear_all  = pend_extra_r;
        last_nxt  = 1'b1;
        state_nxt = ST_START;
      end
      ST_START: begin
        cmd.start_comp = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.rounds_done) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.finish_comp = 1'b1;
        if (last_r) begin
          last_nxt  = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_OUT;
        end else if (final_r) begin
          state_nxt = ST_PAD;
        end else if (pend_extra_r) begin
          state_nxt = ST_LEN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          cmd.shift_out = 1'b1;
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.reset_msg = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pend_extra_nxt = pend_extra_r;
    if (state_r == ST_PAD) begin
      pend_extra_nxt = sts.need_extra;
    end else if (state_r == ST_LEN) begin
      pend_extra_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      final_r      <= 1'b0;
      last_r       <= 1'b0;
      idx_r        <= '0;
      pend_extra_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      final_r      <= final_nxt;
      last_r       <= last_nxt;
      idx_r        <= idx_nxt;
      pend_extra_r <= pend_extra_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/sha256_message_hasher.sv
// Top level of the byte-serial SHA-256 message hasher.
//
//   Channel | Direction | Payload                                | Handshake
//   in_     | sink      | data_byte[7:0], has_byte, final_byte   | in_valid / in_ready
//   out_    | source    | digest_word[31:0], word_index, last_word | out_valid / out_ready
//
// A byte request is stored, then the block fill is checked.
// A request with neither byte nor end mark changes nothing.
// A full block is loaded into the working variables, run through 64 rounds on a
// single round unit and then folded into the hash.
// A final request adds a padding step, a length step and one or two compressions,
// then eight digest words, one per accepted output request. Reset is synchronous and
// active low; it restores the initial hash and clears the counts. The output stalls
// hold the current word and no input request is accepted until the digest has been
// fully taken.
// The extra block of a long tail is compressed after padding; its compression is followed
// by a clear of the whole buffer and the length write.
`default_nettype none
module sha256_message_hasher
  import sha256_pkg::*;
#(
  parameter int unsigned LENGTH_COUNT_BITS = 61
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  sha_cmd_t cmd;
  sha_sts_t sts;
  word_t    hash0;
  logic [2:0] idx;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .has_byte   (in_ch.has_byte),
    .final_byte (in_ch.final_byte),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .word_index (idx),
    .cmd        (cmd),
    .sts        (sts)
  );

  sha256_datapath #(
    .LENGTH_COUNT_BITS (LENGTH_COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_ch.data_byte),
    .sts       (sts),
    .hash0     (hash0)
  );

  assign out_ch.digest_word = hash0;
  assign out_ch.word_index  = idx;
  assign out_ch.last_word   = (idx == 3'd7);

endmodule
`default_nettype wire

FILE: tb/sha256_tb_if.sv
// Request and digest word record types used by the testbench.
`timescale 1ns / 1ps
package sha256_tb_types;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       final_byte;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_req_t;
endpackage

FILE: tb/tb.sv
// Testbench for the byte-serial SHA-256 hasher: a built-in digest model checks every word.
`timescale 1ns / 1ps
module tb;
  import sha256_tb_types::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_message_hasher DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Constants of the standard, held locally so that the model does not lean on the RTL.
  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Model state: running hash, pending block and the 61-bit byte count.
  logic [31:0] run_hash [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [60:0] msg_bytes;

  byte_req_t   pending_reqs [$];
  digest_req_t expected_words [$];

  int unsigned sent_cnt, word_cnt, msg_cnt, err_cnt;
  int unsigned src_idle_pct, snk_idle_pct;
  longint unsigned cycle_cnt;
  bit hold_off;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of blk_bytes into run_hash.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = run_hash[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) run_hash[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) run_hash[i] = HashInit[i];
    blk_fill = 0;
    msg_bytes = '0;
  endtask

  // Absorb one accepted request; on the final one, pad and queue the eight digest words.
  task automatic absorb_request(input byte_req_t req);
    logic [63:0] bit_len;
    digest_req_t dw;
    if (req.has_byte) begin
      blk_bytes[blk_fill] = req.data_byte;
      blk_fill++;
      msg_bytes = msg_bytes + 61'd1;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (req.final_byte) begin
      blk_bytes[blk_fill] = 8'h80;
      for (int i = blk_fill + 1; i < 64; i++) blk_bytes[i] = 8'h00;
      if (blk_fill >= 56) begin
        compress_block();
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
      end
      bit_len = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) blk_bytes[63-i] = bit_len[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = run_hash[i];
        dw.word_index  = 3'(i);
        dw.last_word   = (i == 7);
        expected_words.push_back(dw);
      end
      msg_cnt++;
      restart_message();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Queue a message of len bytes; noise adds byteless non-final requests in between.
  task automatic queue_message(input int len, input bit noise, input bit empty_final);
    byte_req_t r;
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 9) == 0) begin
        r.data_byte = 8'($urandom); r.has_byte = 1'b0; r.final_byte = 1'b0;
        pending_reqs.push_back(r);
      end
      r.data_byte = 8'($urandom);
      r.has_byte  = 1'b1;
      r.final_byte = (!empty_final && i == len - 1);
      pending_reqs.push_back(r);
    end
    if (empty_final || len == 0) begin
      r.data_byte = 8'($urandom); r.has_byte = 1'b0; r.final_byte = 1'b1;
      pending_reqs.push_back(r);
    end
  endtask

  // Request driver: offers the head of the queue, idling at the current rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.has_byte <= 1'b0;
      in_ch.final_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_request({in_ch.data_byte, in_ch.has_byte, in_ch.final_byte});
        sent_cnt++;
      end
      if ((!in_ch.valid || in_ch.ready) && pending_reqs.size() != 0 &&
          $urandom_range(0, 99) >= src_idle_pct) begin
        {in_ch.data_byte, in_ch.has_byte, in_ch.final_byte} <= pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
      end else if (in_ch.valid && in_ch.ready) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Digest monitor: checks each accepted word and drives ready with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        word_cnt++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_ch.digest_word, '0);
        end else begin
          digest_req_t e;
          e = expected_words.pop_front();
          if (out_ch.digest_word !== e.digest_word)
            report_mismatch("digest_word", out_ch.digest_word, e.digest_word);
          if (out_ch.word_index !== e.word_index)
            report_mismatch("word_index", 32'(out_ch.word_index), 32'(e.word_index));
          if (out_ch.last_word !== e.last_word)
            report_mismatch("last_word", 32'(out_ch.last_word), 32'(e.last_word));
        end
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Receiver hold-off: ready is held low right after reset while the sender keeps offering.
  initial begin
    hold_off = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: ends the run with a failure message on timeout.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 400000) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_words.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    sent_cnt = 0; word_cnt = 0; msg_cnt = 0; err_cnt = 0; cycle_cnt = 0;
    src_idle_pct = 14; snk_idle_pct = 73;
    restart_message();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty message, byteless noise, extreme bytes, and the
    // padding boundaries at 55, 56 and 64 bytes, plus a final without a byte.
    queue_message(0, 0, 0);
    begin
      byte_req_t r;
      r = '{data_byte: 8'hff, has_byte: 1'b0, final_byte: 1'b0};
      pending_reqs.push_back(r);
      r = '{data_byte: 8'h00, has_byte: 1'b1, final_byte: 1'b0};
      pending_reqs.push_back(r);
      r = '{data_byte: 8'hff, has_byte: 1'b1, final_byte: 1'b1};
      pending_reqs.push_back(r);
    end
    queue_message(3, 0, 1);
    queue_message(55, 0, 0);
    queue_message(56, 0, 0);
    queue_message(64, 0, 0);
    wait_drained();

    // Random part: short messages with byteless noise and empty finals.
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 73 : 0;
      snk_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 14 : 0;
      for (int m = 0; m < 4; m++) begin
        int len;
        len = $urandom_range(0, 12);
        queue_message(len, 1, $urandom_range(0, 3) == 0);
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d requests in %0d messages, %0d digest words checked.",
             sent_cnt, msg_cnt, word_cnt);
    $display("Included empty, padding-boundary and multi-block messages under stalls.");
    if (err_cnt == 0 && expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

FILE: files.f
src/sha256_pkg.sv
src/sha256_if.sv
src/sha256_datapath.sv
src/sha256_ctrl.sv
src/sha256_message_hasher.sv
tb/sha256_tb_if.sv
tb/tb.sv
